### rtl/crec_pkg.sv
// Shared types, chord codes and pitch helpers for the chord recognizer.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package crec_pkg;

	localparam int NUM_LANES   = 4;
	localparam int NUM_TETRAD  = 13;
	localparam int NOTE_W      = 7;
	localparam int COUNT_W     = 3;
	localparam int PC_W        = 4;
	localparam int KIND_W      = 5;
	localparam int INTERVAL_W  = 12;

	localparam logic [COUNT_W-1:0] COUNT_TRIAD  = 3'd3;
	localparam logic [COUNT_W-1:0] COUNT_TETRAD = 3'd4;

	typedef logic [NOTE_W-1:0]  note_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [PC_W-1:0]    pc_t;
	typedef logic [INTERVAL_W-1:0] ivmap_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_SUS2     = 5'd0,
		KIND_DIM      = 5'd1,
		KIND_MIN      = 5'd2,
		KIND_MAJ      = 5'd3,
		KIND_AUG      = 5'd4,
		KIND_SUS4     = 5'd5,
		KIND_MIN6     = 5'd6,
		KIND_MAJ6     = 5'd7,
		KIND_MAJ7     = 5'd8,
		KIND_MIN7     = 5'd9,
		KIND_DOM7     = 5'd10,
		KIND_M7B5     = 5'd11,
		KIND_DIM7     = 5'd12,
		KIND_MMAJ7    = 5'd13,
		KIND_AUGMAJ7  = 5'd14,
		KIND_AUG7     = 5'd15,
		KIND_MM7B5    = 5'd16,
		KIND_DOM7B5   = 5'd17,
		KIND_MAJ7B5   = 5'd18
	} chord_kind_t;

	// What one root lane found
	typedef struct packed {
		logic        hit;
		chord_kind_t kind;
	} lane_res_t;

	// Merged result of all lanes
	typedef struct packed {
		logic        found;
		note_t       root;
		chord_kind_t kind;
	} chord_res_t;

	// Pitch class of a MIDI note: quotient by 12 through the reciprocal 43/512,
	// exact over the whole 7-bit range
	function automatic pc_t pitch_class(input note_t n);
		logic [12:0] prod;
		logic [3:0]  quo;
		logic [6:0]  rem;
		prod = 13'(n) * 13'd43;
		quo  = prod[12:9];
		rem  = n - 7'(quo) * 7'd12;
		return rem[PC_W-1:0];
	endfunction

	// Interval from root up to other, modulo 12
	function automatic pc_t interval(input pc_t root, input pc_t other);
		logic [PC_W:0] diff;
		diff = {1'b0, other} - {1'b0, root};
		if (diff[PC_W]) begin
			diff = diff + 5'd12;
		end
		return diff[PC_W-1:0];
	endfunction

	// Four-note interval patterns in priority order, starting at the minor sixth
	function automatic ivmap_t tetrad_mask(input logic [3:0] idx);
		ivmap_t m;
		case (idx)
			4'd0:    m = 12'b0010_1000_1000;
			4'd1:    m = 12'b0010_1001_0000;
			4'd2:    m = 12'b1000_1001_0000;
			4'd3:    m = 12'b0100_1000_1000;
			4'd4:    m = 12'b0100_1001_0000;
			4'd5:    m = 12'b0100_0100_1000;
			4'd6:    m = 12'b0010_0100_1000;
			4'd7:    m = 12'b1000_1000_1000;
			4'd8:    m = 12'b1001_0001_0000;
			4'd9:    m = 12'b0101_0001_0000;
			4'd10:   m = 12'b1000_0100_1000;
			4'd11:   m = 12'b0100_0101_0000;
			4'd12:   m = 12'b1000_0101_0000;
			default: m = '1;
		endcase
		return m;
	endfunction

endpackage

### rtl/crec_if.sv
// Valid/ready channel interfaces for chord input and recognition result.
// Depends on crec_pkg for the payload types.
`timescale 1ns / 1ps

interface crec_chord_if;
	logic           valid;
	logic           ready;
	crec_pkg::count_t note_count;
	crec_pkg::note_t  note_a;
	crec_pkg::note_t  note_b;
	crec_pkg::note_t  note_c;
	crec_pkg::note_t  note_d;

	modport source (output valid, note_count, note_a, note_b, note_c, note_d, input ready);
	modport sink   (input valid, note_count, note_a, note_b, note_c, note_d, output ready);
endinterface

interface crec_result_if;
	logic                  valid;
	logic                  ready;
	logic                  found;
	crec_pkg::note_t       root_note;
	logic [crec_pkg::KIND_W-1:0] chord_kind;

	modport source (output valid, found, root_note, chord_kind, input ready);
	modport sink   (input valid, found, root_note, chord_kind, output ready);
endinterface

### rtl/crec_lane.sv
// One root lane: tries its note slot as the root against four-note patterns, and against triads in slots 0 to 2.
// Depends on crec_pkg for pitch helpers, pattern masks and chord codes.
`timescale 1ns / 1ps

module crec_lane #(
	parameter int unsigned LANE_IDX = 0
) (
	input  crec_pkg::pc_t [crec_pkg::NUM_LANES-1:0] pc,
	input  crec_pkg::count_t                        note_count,
	input  logic                                    sus2_enable,
	output crec_pkg::lane_res_t                     res
);

	localparam logic       TRIAD_LANE = (LANE_IDX < 3);
	localparam logic [1:0] R_SEL      = 2'(LANE_IDX);
	localparam logic [1:0] T_SEL      = 2'((LANE_IDX + 1) % 3);
	localparam logic [1:0] F_SEL      = 2'((LANE_IDX + 2) % 3);

	crec_pkg::pc_t         t_iv;
	crec_pkg::pc_t         f_iv;
	logic                  tri_hit;
	crec_pkg::chord_kind_t tri_kind;
	crec_pkg::ivmap_t      present;
	logic                  tet_hit;
	crec_pkg::chord_kind_t tet_kind;

	// Match the rotation that starts at this slot
	always_comb begin
		t_iv     = crec_pkg::interval(pc[R_SEL], pc[T_SEL]);
		f_iv     = crec_pkg::interval(pc[R_SEL], pc[F_SEL]);
		tri_hit  = TRIAD_LANE;
		tri_kind = crec_pkg::KIND_SUS2;
		if (sus2_enable && t_iv == 4'd2 && f_iv == 4'd7) begin
			tri_kind = crec_pkg::KIND_SUS2;
		end else if (t_iv == 4'd3 && f_iv == 4'd6) begin
			tri_kind = crec_pkg::KIND_DIM;
		end else if (t_iv == 4'd3 && f_iv == 4'd7) begin
			tri_kind = crec_pkg::KIND_MIN;
		end else if (t_iv == 4'd4 && f_iv == 4'd7) begin
			tri_kind = crec_pkg::KIND_MAJ;
		end else if (t_iv == 4'd4 && f_iv == 4'd8) begin
			tri_kind = crec_pkg::KIND_AUG;
		end else if (t_iv == 4'd5 && f_iv == 4'd7) begin
			tri_kind = crec_pkg::KIND_SUS4;
		end else begin
			tri_hit = 1'b0;
		end
	end

	// Build the interval map of the other three notes and scan the patterns
	always_comb begin
		present = '0;
		for (int j = 0; j < crec_pkg::NUM_LANES; j++) begin
			if (j != LANE_IDX) begin
				present = present | (crec_pkg::ivmap_t'(1) <<
					crec_pkg::interval(pc[R_SEL], pc[j]));
			end
		end
		tet_hit  = 1'b0;
		tet_kind = crec_pkg::KIND_MIN6;
		// Walk backward so the earliest pattern in priority wins
		for (int p = crec_pkg::NUM_TETRAD - 1; p >= 0; p--) begin
			if ((present & crec_pkg::tetrad_mask(4'(p))) == crec_pkg::tetrad_mask(4'(p))) begin
				tet_hit  = 1'b1;
				tet_kind = crec_pkg::chord_kind_t'(5'(crec_pkg::KIND_MIN6) + 5'(p));
			end
		end
	end

	// Select by note count
	always_comb begin
		case (note_count)
			crec_pkg::COUNT_TRIAD: begin
				res.hit  = tri_hit;
				res.kind = tri_kind;
			end
			crec_pkg::COUNT_TETRAD: begin
				res.hit  = tet_hit;
				res.kind = tet_kind;
			end
			default: begin
				res.hit  = 1'b0;
				res.kind = crec_pkg::KIND_SUS2;
			end
		endcase
	end

endmodule

### rtl/crec_merge.sv
// Merge stage: picks the first lane in slot order that matched, and its root note.
// Depends on crec_pkg for lane and result structs.
`timescale 1ns / 1ps

module crec_merge (
	input  crec_pkg::lane_res_t [crec_pkg::NUM_LANES-1:0] lanes,
	input  crec_pkg::note_t     [crec_pkg::NUM_LANES-1:0] notes,
	output crec_pkg::chord_res_t                          res
);

	// Priority select, lowest slot wins; no hit gives all zeros
	always_comb begin
		res.found = 1'b0;
		res.root  = '0;
		res.kind  = crec_pkg::KIND_SUS2;
		for (int i = crec_pkg::NUM_LANES - 1; i >= 0; i--) begin
			if (lanes[i].hit) begin
				res.found = 1'b1;
				res.root  = notes[i];
				res.kind  = lanes[i].kind;
			end
		end
	end

endmodule

### rtl/chord_recognizer_unit.sv
// Top of the chord recognizer: input register, four root lanes, lane result register, merge, output register.
// Depends on crec_pkg, crec_if, crec_lane and crec_merge.
`timescale 1ns / 1ps

// Usage
//   chord:  valid/ready channel carrying note_count and four MIDI notes; one
//           transfer is one chord. note_d is ignored for a three-note chord.
//   result: valid/ready channel carrying found, root_note and chord_kind;
//           exactly one result per chord, in order.
//   cfg_we/cfg_wdata: writes sus2_enable; write only while no chord is in flight.
// Path: a chord passes the pitch-class register, the lane result register and the
//   output register before its result shows on the output.
// Throughput: one chord per cycle while the output is not stalled. All four root
//   slots are matched at once by four lanes.
// Stall: each stage loads when it is empty or the stage after it moves, so a
//   chord is still taken while a finished result waits; with every stage full
//   and result.ready low, chord.ready drops and everything holds.
// Reset: arst_n clears all stage valids and sets sus2_enable to 1.
module chord_recognizer_unit (
	input  logic                     clk,
	input  logic                     arst_n,
	crec_chord_if.sink               chord,
	crec_result_if.source            result,
	input  logic                     cfg_we,
	input  logic                     cfg_wdata
);

	logic sus2_enable_q;

	logic                                         valid_s1;
	crec_pkg::count_t                             count_s1;
	crec_pkg::pc_t   [crec_pkg::NUM_LANES-1:0]    pc_s1;
	crec_pkg::note_t [crec_pkg::NUM_LANES-1:0]    note_s1;

	logic                                         valid_s2;
	crec_pkg::lane_res_t [crec_pkg::NUM_LANES-1:0] lane_s2;
	crec_pkg::note_t     [crec_pkg::NUM_LANES-1:0] note_s2;

	logic                  out_valid_q;
	crec_pkg::chord_res_t  out_res_q;

	logic en_s1;
	logic en_s2;
	logic en_out;

	crec_pkg::note_t     [crec_pkg::NUM_LANES-1:0] note_in;
	crec_pkg::lane_res_t [crec_pkg::NUM_LANES-1:0] lane_res;
	crec_pkg::chord_res_t                          merged;

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sus2_enable_q <= 1'b1;
		end else if (cfg_we) begin
			sus2_enable_q <= cfg_wdata;
		end
	end

	// Stage enables: load when empty or when the next stage moves
	assign en_out = !out_valid_q || result.ready;
	assign en_s2  = !valid_s2 || en_out;
	assign en_s1  = !valid_s1 || en_s2;
	assign chord.ready = en_s1;

	assign note_in = {chord.note_d, chord.note_c, chord.note_b, chord.note_a};

	// Stage 1: capture notes and their pitch classes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en_s1) begin
			valid_s1 <= chord.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && chord.valid) begin
			count_s1 <= chord.note_count;
			note_s1  <= note_in;
			for (int i = 0; i < crec_pkg::NUM_LANES; i++) begin
				pc_s1[i] <= crec_pkg::pitch_class(note_in[i]);
			end
		end
	end

	// Root lanes, one per note slot
	for (genvar g = 0; g < crec_pkg::NUM_LANES; g++) begin : g_lane
		crec_lane #(
			.LANE_IDX (g)
		) u_lane (
			.pc          (pc_s1),
			.note_count  (count_s1),
			.sus2_enable (sus2_enable_q),
			.res         (lane_res[g])
		);
	end

	// Stage 2: hold lane results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			lane_s2 <= lane_res;
			note_s2 <= note_s1;
		end
	end

	crec_merge u_merge (
		.lanes (lane_s2),
		.notes (note_s2),
		.res   (merged)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && valid_s2) begin
			out_res_q <= merged;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.found      = out_res_q.found;
	assign result.root_note  = out_res_q.root;
	assign result.chord_kind = out_res_q.kind;

`ifndef SYNTHESIS
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_res_q.found |-> out_res_q.root == '0 &&
			out_res_q.kind == crec_pkg::KIND_SUS2)
		else $error("not-found result carries nonzero root or kind");

	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_res_q.found |-> out_res_q.kind <= crec_pkg::KIND_MAJ7B5)
		else $error("chord kind out of range");

	a_take_into_s1: assert property (@(posedge clk) disable iff (!arst_n)
		chord.valid && chord.ready |=> valid_s1)
		else $error("transferred chord did not reach stage 1");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> chord.ready)
		else $error("empty front stage refuses a chord");

	a_bad_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && en_s2 && count_s1 != crec_pkg::COUNT_TRIAD &&
			count_s1 != crec_pkg::COUNT_TETRAD |=> !(|{lane_s2[0].hit,
			lane_s2[1].hit, lane_s2[2].hit, lane_s2[3].hit}))
		else $error("lane hit on an unsupported note count");
`endif

endmodule
